### rtl/rxrot_pkg.sv
`default_nettype none

package rxrot_pkg;

  typedef enum logic [2:0] {
    REQ_DESC_DONE  = 3'd0,
    REQ_DESC_ERROR = 3'd1,
    REQ_UNEXP_EOF  = 3'd2,
    REQ_TAKE       = 3'd3,
    REQ_RELEASE    = 3'd4,
    REQ_START      = 3'd5,
    REQ_STOP       = 3'd6,
    REQ_READ_CNT   = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_QUEUE_EMPTY = 2'd1,
    ST_BAD_STATE   = 2'd2,
    ST_BAD_ARG     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FLT_NONE       = 3'd0,
    FLT_DESC       = 3'd1,
    FLT_EOF        = 3'd2,
    FLT_FIFO       = 3'd3,
    FLT_DMA        = 3'd4,
    FLT_QUEUE_FULL = 3'd5,
    FLT_BLOCK      = 3'd6
  } fault_e;

  typedef enum logic [1:0] {
    OWN_DMA   = 2'd0,
    OWN_READY = 2'd1,
    OWN_PROC  = 2'd2
  } owner_e;

  localparam int unsigned NumCounters = 7;
  localparam int unsigned CntDescs    = 0;
  localparam int unsigned CntBlocks   = 1;
  localparam int unsigned CntDescErr  = 2;
  localparam int unsigned CntOverrun  = 3;
  localparam int unsigned CntFifo     = 4;
  localparam int unsigned CntQFull    = 5;
  localparam int unsigned CntEof      = 6;

  localparam logic [11:0] DescBytesReset = 12'd4092;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [11:0] desc_length;
    logic [11:0] desc_size;
    logic        fifo_overflow;
    logic [2:0]  release_index;
    logic [2:0]  counter_select;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  out_block_index;
    logic [31:0] out_sequence;
    logic [31:0] counter_value;
    logic        is_running;
    logic        is_stopping;
    logic        is_fatal;
    logic [2:0]  first_fault;
  } res_t;

endpackage

`default_nettype wire

### rtl/rx_block_ring_ownership_tracker_top.sv
`default_nettype none

// Receive ring ownership tracker.
// Input channel: an item (req_i) is accepted at a rising edge where start is
// high and busy is low. The block never raises busy, so an item may be
// given in every cycle.
// Output channel: each accepted item yields exactly one result on res_o,
// marked by res_valid_o for one cycle via in_valid_q and res_valid_q. The
// receiver cannot stall; results leave in item order at one per cycle.
// The first stage registers the item; the second applies it to the ring,
// owner, queue and counter state and registers the result in the same cycle,
// so back-to-back items see each other's updates.
// Configuration: cfg_we_i with cfg_wdata_i writes the expected descriptor
// size. Write it only while no item is in flight.
// Reset clears all flags, the ring position, owners, sequence number, queue
// count and counters, and sets the descriptor size to 4092. Queue entries
// are not cleared; they are only read below the fill count.
module rx_block_ring_ownership_tracker_top #(
  parameter int unsigned BLOCK_COUNT     = 4,
  parameter int unsigned DESCS_PER_BLOCK = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire rxrot_pkg::req_t req_i,
  input  wire logic            cfg_we_i,
  input  wire logic [11:0]     cfg_wdata_i,
  output logic                 res_valid_o,
  output rxrot_pkg::res_t      res_o
);
  import rxrot_pkg::*;

  localparam int unsigned IdxW  = $clog2(BLOCK_COUNT);
  localparam int unsigned DescW = (DESCS_PER_BLOCK > 1) ? $clog2(DESCS_PER_BLOCK) : 1;
  localparam int unsigned CntW  = $clog2(BLOCK_COUNT + 1);

  logic                 in_valid_q;
  req_t                 req_q;
  logic [11:0]          cfg_q;
  logic                 run_q, run_d;
  logic                 stop_q, stop_d;
  logic                 fatal_q, fatal_d;
  fault_e               code_q, code_d;
  logic [DescW-1:0]     desc_q, desc_d;
  logic [IdxW-1:0]      blk_q, blk_d;
  owner_e               owner_q [BLOCK_COUNT];
  owner_e               owner_d [BLOCK_COUNT];
  logic [31:0]          seq_q, seq_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [IdxW-1:0]      head_q, head_d;
  logic [IdxW-1:0]      fifo_idx_q [BLOCK_COUNT];
  logic [31:0]          fifo_seq_q [BLOCK_COUNT];
  logic [31:0]          cnt_q [NumCounters];
  logic                 res_valid_q;
  res_t                 res_q, res_d;

  logic [NumCounters-1:0] bump;
  logic                   clear;
  logic                   fault;
  fault_e                 fault_code;
  logic                   fifo_we;
  logic [IdxW-1:0]        slot;
  logic [IdxW:0]          slot_sum;
  logic [IdxW-1:0]        next_blk;
  logic [IdxW-1:0]        head_idx;
  logic [IdxW-1:0]        rel_idx;
  logic [IdxW-1:0]        oidx;
  status_e                status;

  assign busy = 1'b0;

  assign next_blk = (blk_q == IdxW'(BLOCK_COUNT - 1)) ? '0 : blk_q + 1'b1;
  assign slot_sum = (IdxW + 1)'(head_q) + (IdxW + 1)'(count_q);
  assign slot     = (slot_sum >= (IdxW + 1)'(BLOCK_COUNT))
                  ? IdxW'(slot_sum - (IdxW + 1)'(BLOCK_COUNT)) : IdxW'(slot_sum);
  assign head_idx = fifo_idx_q[head_q];
  assign rel_idx  = IdxW'(req_q.release_index);

  always_comb begin
    run_d      = run_q;
    stop_d     = stop_q;
    fatal_d    = fatal_q;
    code_d     = code_q;
    desc_d     = desc_q;
    blk_d      = blk_q;
    owner_d    = owner_q;
    seq_d      = seq_q;
    count_d    = count_q;
    head_d     = head_q;
    bump       = '0;
    clear      = 1'b0;
    fault      = 1'b0;
    fault_code = FLT_NONE;
    fifo_we    = 1'b0;
    status     = ST_OK;
    oidx       = '0;
    res_d      = '0;

    unique case (req_e'(req_q.req_type))
      REQ_DESC_DONE: begin
        if (run_q && !stop_q) begin
          if (req_q.fifo_overflow) begin
            bump[CntFifo]    = 1'b1;
            bump[CntOverrun] = 1'b1;
            fault            = 1'b1;
            fault_code       = FLT_FIFO;
          end else if (req_q.desc_length != req_q.desc_size ||
                       req_q.desc_size != cfg_q) begin
            bump[CntDescErr] = 1'b1;
            fault            = 1'b1;
            fault_code       = FLT_DESC;
          end else begin
            bump[CntDescs] = 1'b1;
            if (desc_q == DescW'(DESCS_PER_BLOCK - 1)) begin
              desc_d = '0;
              blk_d  = next_blk;
              if (owner_q[next_blk] != OWN_DMA || owner_q[blk_q] != OWN_DMA) begin
                bump[CntOverrun] = 1'b1;
                fault            = 1'b1;
                fault_code       = FLT_DMA;
              end else begin
                owner_d[blk_q]  = OWN_READY;
                bump[CntBlocks] = 1'b1;
                seq_d           = seq_q + 32'd1;
                if (count_q >= CntW'(BLOCK_COUNT)) begin
                  bump[CntQFull] = 1'b1;
                  fault          = 1'b1;
                  fault_code     = FLT_QUEUE_FULL;
                end else begin
                  fifo_we = 1'b1;
                  count_d = count_q + 1'b1;
                end
              end
            end else begin
              desc_d = desc_q + 1'b1;
            end
          end
        end
      end
      REQ_DESC_ERROR: begin
        if (run_q && !stop_q) begin
          bump[CntDescErr] = 1'b1;
          fault            = 1'b1;
          fault_code       = FLT_DESC;
        end
      end
      REQ_UNEXP_EOF: begin
        if (run_q && !stop_q) begin
          bump[CntEof] = 1'b1;
          fault        = 1'b1;
          fault_code   = FLT_EOF;
        end
      end
      REQ_TAKE: begin
        if (count_q == '0) begin
          status = ST_QUEUE_EMPTY;
        end else begin
          head_d  = (head_q == IdxW'(BLOCK_COUNT - 1)) ? '0 : head_q + 1'b1;
          count_d = count_q - 1'b1;
          if (32'(head_idx) >= BLOCK_COUNT || owner_q[head_idx] != OWN_READY) begin
            fault      = 1'b1;
            fault_code = FLT_BLOCK;
            status     = ST_BAD_STATE;
          end else begin
            owner_d[head_idx]  = OWN_PROC;
            oidx               = head_idx;
            res_d.out_sequence = fifo_seq_q[head_q];
          end
        end
      end
      REQ_RELEASE: begin
        if (32'(req_q.release_index) >= BLOCK_COUNT) begin
          status = ST_BAD_ARG;
        end else if (owner_q[rel_idx] != OWN_PROC) begin
          fault      = 1'b1;
          fault_code = FLT_BLOCK;
          status     = ST_BAD_STATE;
        end else begin
          owner_d[rel_idx] = OWN_DMA;
        end
      end
      REQ_START: begin
        if (run_q) begin
          status = ST_BAD_STATE;
        end else begin
          clear   = 1'b1;
          run_d   = 1'b1;
          stop_d  = 1'b0;
          fatal_d = 1'b0;
          code_d  = FLT_NONE;
          desc_d  = '0;
          blk_d   = '0;
          seq_d   = '0;
          count_d = '0;
          head_d  = '0;
          for (int i = 0; i < BLOCK_COUNT; i++) begin
            owner_d[i] = OWN_DMA;
          end
        end
      end
      REQ_STOP: begin
        stop_d = 1'b1;
        run_d  = 1'b0;
      end
      REQ_READ_CNT: begin
        if (32'(req_q.counter_select) >= NumCounters) begin
          status = ST_BAD_ARG;
        end else begin
          res_d.counter_value = cnt_q[req_q.counter_select];
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase

    if (fault && !stop_q) begin
      if (!fatal_q) begin
        code_d = fault_code;
      end
      fatal_d = 1'b1;
      run_d   = 1'b0;
    end

    res_d.status          = status;
    res_d.out_block_index = 2'(oidx);
    res_d.is_running      = run_d;
    res_d.is_stopping     = stop_d;
    res_d.is_fatal        = fatal_d;
    res_d.first_fault     = code_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      cfg_q       <= DescBytesReset;
      run_q       <= 1'b0;
      stop_q      <= 1'b0;
      fatal_q     <= 1'b0;
      code_q      <= FLT_NONE;
      desc_q      <= '0;
      blk_q       <= '0;
      seq_q       <= '0;
      count_q     <= '0;
      head_q      <= '0;
      for (int i = 0; i < BLOCK_COUNT; i++) begin
        owner_q[i] <= OWN_DMA;
      end
      for (int i = 0; i < NumCounters; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      in_valid_q  <= start;
      res_valid_q <= in_valid_q;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (in_valid_q) begin
        run_q   <= run_d;
        stop_q  <= stop_d;
        fatal_q <= fatal_d;
        code_q  <= code_d;
        desc_q  <= desc_d;
        blk_q   <= blk_d;
        seq_q   <= seq_d;
        count_q <= count_d;
        head_q  <= head_d;
        owner_q <= owner_d;
        for (int i = 0; i < NumCounters; i++) begin
          if (clear) begin
            cnt_q[i] <= '0;
          end else if (bump[i] && cnt_q[i] != '1) begin
            cnt_q[i] <= cnt_q[i] + 32'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_i;
    res_q <= res_d;
    if (in_valid_q && fifo_we) begin
      fifo_idx_q[slot] <= blk_q;
      fifo_seq_q[slot] <= seq_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### dv/rx_ring_tracker_checker.sv
module rx_ring_tracker_checker #(
  parameter int unsigned BLOCK_COUNT     = 4,
  parameter int unsigned DESCS_PER_BLOCK = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            busy_i,
  input  wire rxrot_pkg::req_t req_i,
  input  wire logic            cfg_we_i,
  input  wire logic [11:0]     cfg_wdata_i,
  input  wire logic            res_valid_i,
  input  wire rxrot_pkg::res_t res_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  import rxrot_pkg::*;

  localparam int unsigned RingLen = BLOCK_COUNT * DESCS_PER_BLOCK;

  logic [11:0] desc_bytes;
  logic        running;
  logic        stopping;
  logic        fatal;
  fault_e      first_fault;
  int unsigned ring_pos;
  owner_e      owner [BLOCK_COUNT];
  logic [31:0] seq_num;
  int unsigned ready_idx [BLOCK_COUNT];
  logic [31:0] ready_seq [BLOCK_COUNT];
  int unsigned ready_fill;
  int unsigned ready_head;
  logic [31:0] event_cnt [NumCounters];

  res_t pending_replies[$];
  int   mismatches  = 0;
  int   outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  function automatic void clear_ring_state();
    running     = 1'b0;
    stopping    = 1'b0;
    fatal       = 1'b0;
    first_fault = FLT_NONE;
    ring_pos    = 0;
    seq_num     = '0;
    ready_fill  = 0;
    ready_head  = 0;
    for (int i = 0; i < BLOCK_COUNT; i++) begin
      owner[i]     = OWN_DMA;
      ready_idx[i] = 0;
      ready_seq[i] = '0;
    end
    for (int i = 0; i < NumCounters; i++) begin
      event_cnt[i] = '0;
    end
  endfunction

  function automatic void bump(int unsigned which);
    if (event_cnt[which] != '1) begin
      event_cnt[which] = event_cnt[which] + 32'd1;
    end
  endfunction

  function automatic void raise_fault(fault_e code);
    if (stopping) begin
      return;
    end
    if (!fatal) begin
      first_fault = code;
    end
    fatal   = 1'b1;
    running = 1'b0;
  endfunction

  function automatic void finish_descriptor(req_t r);
    int unsigned done_blk;
    int unsigned next_blk;
    int unsigned slot;
    if (!running || stopping) begin
      return;
    end
    if (r.fifo_overflow) begin
      bump(CntFifo);
      bump(CntOverrun);
      raise_fault(FLT_FIFO);
      return;
    end
    if (r.desc_length != r.desc_size || r.desc_size != desc_bytes) begin
      bump(CntDescErr);
      raise_fault(FLT_DESC);
      return;
    end
    ring_pos = (ring_pos + 1) % RingLen;
    bump(CntDescs);
    if ((ring_pos % DESCS_PER_BLOCK) != 0) begin
      return;
    end
    done_blk = (ring_pos / DESCS_PER_BLOCK + BLOCK_COUNT - 1) % BLOCK_COUNT;
    next_blk = (done_blk + 1) % BLOCK_COUNT;
    if (owner[next_blk] != OWN_DMA || owner[done_blk] != OWN_DMA) begin
      bump(CntOverrun);
      raise_fault(FLT_DMA);
      return;
    end
    owner[done_blk] = OWN_READY;
    bump(CntBlocks);
    seq_num = seq_num + 32'd1;
    if (ready_fill >= BLOCK_COUNT) begin
      bump(CntQFull);
      raise_fault(FLT_QUEUE_FULL);
      return;
    end
    slot            = (ready_head + ready_fill) % BLOCK_COUNT;
    ready_idx[slot] = done_blk;
    ready_seq[slot] = seq_num;
    ready_fill++;
  endfunction

  function automatic res_t apply_ring_request(req_t r);
    res_t        o;
    int unsigned idx;
    logic [31:0] seq;
    o        = '0;
    o.status = ST_OK;
    case (req_e'(r.req_type))
      REQ_DESC_DONE: begin
        finish_descriptor(r);
      end
      REQ_DESC_ERROR: begin
        if (running && !stopping) begin
          bump(CntDescErr);
          raise_fault(FLT_DESC);
        end
      end
      REQ_UNEXP_EOF: begin
        if (running && !stopping) begin
          bump(CntEof);
          raise_fault(FLT_EOF);
        end
      end
      REQ_TAKE: begin
        if (ready_fill == 0) begin
          o.status = ST_QUEUE_EMPTY;
        end else begin
          idx        = ready_idx[ready_head];
          seq        = ready_seq[ready_head];
          ready_head = (ready_head + 1) % BLOCK_COUNT;
          ready_fill--;
          if (idx >= BLOCK_COUNT || owner[idx] != OWN_READY) begin
            raise_fault(FLT_BLOCK);
            o.status = ST_BAD_STATE;
          end else begin
            owner[idx]        = OWN_PROC;
            o.out_block_index = 2'(idx);
            o.out_sequence    = seq;
          end
        end
      end
      REQ_RELEASE: begin
        idx = r.release_index;
        if (idx >= BLOCK_COUNT) begin
          o.status = ST_BAD_ARG;
        end else if (owner[idx] != OWN_PROC) begin
          raise_fault(FLT_BLOCK);
          o.status = ST_BAD_STATE;
        end else begin
          owner[idx] = OWN_DMA;
        end
      end
      REQ_START: begin
        if (running) begin
          o.status = ST_BAD_STATE;
        end else begin
          clear_ring_state();
          running = 1'b1;
        end
      end
      REQ_STOP: begin
        stopping = 1'b1;
        running  = 1'b0;
      end
      default: begin
        if (r.counter_select >= NumCounters) begin
          o.status = ST_BAD_ARG;
        end else begin
          o.counter_value = event_cnt[r.counter_select];
        end
      end
    endcase
    o.is_running  = running;
    o.is_stopping = stopping;
    o.is_fatal    = fatal;
    o.first_fault = first_fault;
    return o;
  endfunction

  function automatic void report(string field, logic [31:0] exp_v, logic [31:0] got_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, got_v);
    mismatches++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    if (!rst_ni) begin
      desc_bytes = DescBytesReset;
      clear_ring_state();
      pending_replies.delete();
      outstanding = 0;
    end else begin
      if (res_valid_i) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: result with no item pending, actual %0h", $time, res_i);
          mismatches++;
        end else begin
          exp_r = pending_replies.pop_front();
          if (res_i.status !== exp_r.status)
            report("status", exp_r.status, res_i.status);
          if (res_i.out_block_index !== exp_r.out_block_index)
            report("out_block_index", exp_r.out_block_index, res_i.out_block_index);
          if (res_i.out_sequence !== exp_r.out_sequence)
            report("out_sequence", exp_r.out_sequence, res_i.out_sequence);
          if (res_i.counter_value !== exp_r.counter_value)
            report("counter_value", exp_r.counter_value, res_i.counter_value);
          if (res_i.is_running !== exp_r.is_running)
            report("is_running", exp_r.is_running, res_i.is_running);
          if (res_i.is_stopping !== exp_r.is_stopping)
            report("is_stopping", exp_r.is_stopping, res_i.is_stopping);
          if (res_i.is_fatal !== exp_r.is_fatal)
            report("is_fatal", exp_r.is_fatal, res_i.is_fatal);
          if (res_i.first_fault !== exp_r.first_fault)
            report("first_fault", exp_r.first_fault, res_i.first_fault);
        end
      end
      if (cfg_we_i) begin
        desc_bytes = cfg_wdata_i;
      end
      if (start_i && !busy_i) begin
        pending_replies.push_back(apply_ring_request(req_i));
      end
      outstanding = pending_replies.size();
    end
  end

endmodule

### dv/testbench.sv
module testbench;
  import rxrot_pkg::*;

  localparam int unsigned BlockCount    = 4;
  localparam int unsigned DescsPerBlock = 4;
  localparam int unsigned PhaseItems    = 108;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  req_t        req       = '0;
  logic        cfg_we    = 1'b0;
  logic [11:0] cfg_wdata = '0;
  logic        res_valid;
  res_t        res;
  int          fail_count;
  int          pending;

  int unsigned max_gap      = 10;
  logic [11:0] cfg_now      = DescBytesReset;
  logic        last_running = 1'b0;
  int unsigned taken_blocks[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rx_block_ring_ownership_tracker_top #(
    .BLOCK_COUNT    (BlockCount),
    .DESCS_PER_BLOCK(DescsPerBlock)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  rx_ring_tracker_checker #(
    .BLOCK_COUNT    (BlockCount),
    .DESCS_PER_BLOCK(DescsPerBlock)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .res_valid_i (res_valid),
    .res_i       (res),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Blocks handed out by take requests are remembered so that most releases are legal.
  always @(posedge clk_i) begin
    if (res_valid) begin
      last_running = res.is_running;
      if (res.status == ST_OK && res.out_sequence != '0) begin
        taken_blocks.push_back(res.out_block_index);
      end
    end
  end

  function automatic req_t mk_req(req_e kind, logic [11:0] len, logic [11:0] size,
                                  logic ovf, logic [2:0] rel, logic [2:0] sel);
    req_t r;
    r.req_type       = kind;
    r.desc_length    = len;
    r.desc_size      = size;
    r.fifo_overflow  = ovf;
    r.release_index  = rel;
    r.counter_select = sel;
    return r;
  endfunction

  task automatic send_request(req_t r);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (req_e'(r.req_type) == REQ_START) begin
      taken_blocks.delete();
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain(int unsigned settle);
    start <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_desc_bytes(logic [11:0] value);
    drain(4);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cfg_now = value;
  endtask

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    r.req_type       = 3'($urandom);
    r.desc_length    = 12'($urandom);
    r.desc_size      = 12'($urandom);
    r.fifo_overflow  = 1'($urandom);
    r.release_index  = 3'($urandom);
    r.counter_select = 3'($urandom);
    pick = $urandom_range(0, 99);
    if (!last_running && pick < 60) begin
      r.req_type = REQ_START;
    end else if (pick < 55) begin
      r.req_type      = REQ_DESC_DONE;
      r.desc_length   = cfg_now;
      r.desc_size     = cfg_now;
      r.fifo_overflow = 1'b0;
    end else if (pick < 70) begin
      r.req_type = REQ_TAKE;
    end else if (pick < 82) begin
      r.req_type = REQ_RELEASE;
      if (taken_blocks.size() > 0 && $urandom_range(0, 7) != 0) begin
        r.release_index = 3'(taken_blocks.pop_front());
      end
    end else if (pick < 86) begin
      r.req_type = REQ_READ_CNT;
    end else if (pick < 89) begin
      r.req_type = REQ_START;
    end else if (pick < 91) begin
      r.req_type = REQ_STOP;
    end else if (pick < 94) begin
      r.req_type = REQ_DESC_DONE;
      if ($urandom_range(0, 1) == 0) begin
        r.desc_size = cfg_now;
      end
    end else if (pick < 96) begin
      r.req_type = REQ_DESC_ERROR;
    end else if (pick < 97) begin
      r.req_type = REQ_UNEXP_EOF;
    end
    return r;
  endfunction

  initial begin
    logic [11:0] phase_cfg [4];
    phase_cfg[0] = 12'd1;
    phase_cfg[1] = 12'hFFF;
    phase_cfg[2] = 12'($urandom_range(1, 4095));
    phase_cfg[3] = DescBytesReset;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(mk_req(REQ_READ_CNT, 12'd0, 12'd0, 1'b0, 3'd0, 3'd7));
    send_request(mk_req(REQ_READ_CNT, 12'd0, 12'd0, 1'b0, 3'd0, 3'd0));
    send_request(mk_req(REQ_DESC_DONE, DescBytesReset, DescBytesReset, 1'b0, 3'd0, 3'd0));
    send_request(mk_req(REQ_TAKE, 12'd0, 12'd0, 1'b0, 3'd0, 3'd0));
    send_request(mk_req(REQ_RELEASE, 12'd0, 12'd0, 1'b0, 3'd7, 3'd0));
    send_request(mk_req(REQ_RELEASE, 12'd0, 12'd0, 1'b0, 3'd2, 3'd0));
    send_request(mk_req(REQ_START, 12'd0, 12'd0, 1'b0, 3'd0, 3'd0));
    send_request(mk_req(REQ_START, 12'hFFF, 12'hFFF, 1'b1, 3'd7, 3'd7));
    repeat (4) begin
      send_request(mk_req(REQ_DESC_DONE, DescBytesReset, DescBytesReset, 1'b0, 3'd0, 3'd0));
    end
    send_request(mk_req(REQ_TAKE, 12'd0, 12'd0, 1'b0, 3'd0, 3'd0));
    send_request(mk_req(REQ_RELEASE, 12'd0, 12'd0, 1'b0, 3'd0, 3'd0));
    send_request(mk_req(REQ_DESC_DONE, 12'hFFF, 12'd0, 1'b0, 3'd0, 3'd0));
    send_request(mk_req(REQ_DESC_ERROR, 12'd0, 12'd0, 1'b0, 3'd0, 3'd0));
    send_request(mk_req(REQ_START, 12'd0, 12'd0, 1'b0, 3'd0, 3'd0));
    send_request(mk_req(REQ_UNEXP_EOF, 12'd0, 12'd0, 1'b0, 3'd0, 3'd0));
    send_request(mk_req(REQ_START, 12'd0, 12'd0, 1'b0, 3'd0, 3'd0));
    send_request(mk_req(REQ_DESC_DONE, 12'hFFF, 12'hFFF, 1'b1, 3'd0, 3'd0));
    send_request(mk_req(REQ_START, 12'd0, 12'd0, 1'b0, 3'd0, 3'd0));
    send_request(mk_req(REQ_DESC_ERROR, 12'd0, 12'd0, 1'b0, 3'd0, 3'd0));
    send_request(mk_req(REQ_STOP, 12'd0, 12'd0, 1'b0, 3'd0, 3'd0));
    send_request(mk_req(REQ_RELEASE, 12'd0, 12'd0, 1'b0, 3'd1, 3'd0));
    send_request(mk_req(REQ_READ_CNT, 12'd0, 12'd0, 1'b0, 3'd0, 3'd2));

    for (int p = 0; p < 4; p++) begin
      write_desc_bytes(phase_cfg[p]);
      for (int k = 0; k < PhaseItems; k++) begin
        if (k % 27 == 0) begin
          max_gap = ($urandom_range(0, 2) == 0) ? 0 : 10;
        end
        if (k == PhaseItems / 2) begin
          drain(0);
        end
        send_request(random_request());
      end
    end

    drain(10);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
